FILE: hdl/swa_pkg.sv
package swa_pkg;

  // Field widths
  localparam int EXT_W      = 11;
  localparam int STRIDE_W   = 24;
  localparam int BASE_W     = 32;
  localparam int POS_W      = 10;
  localparam int COUNT_W    = 30;
  localparam int OUT_ADDR_W = 32;
  localparam int PROD_W     = STRIDE_W + POS_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_REG_DIMS = 3;

  // Parameter defaults
  localparam int MAX_DIMS_DEF  = 3;
  localparam int ADDR_BITS_DEF = 32;

  // Largest extent a dimension may have
  localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1024);

  // Reset values
  localparam logic [EXT_W-1:0]    EXT_RST          = EXT_W'(1);
  localparam logic [STRIDE_W-1:0] STRIDE_RST       = '0;
  localparam logic [STRIDE_W-1:0] STRIDE_INNER_RST = STRIDE_W'(1);
  localparam logic [BASE_W-1:0]   BASE_RST         = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXT_OUTER    = 3'd0,
    CFG_EXT_MIDDLE   = 3'd1,
    CFG_EXT_INNER    = 3'd2,
    CFG_STRIDE_OUTER = 3'd3,
    CFG_STRIDE_MIDDLE = 3'd4,
    CFG_STRIDE_INNER = 3'd5,
    CFG_BASE_OFFSET  = 3'd6
  } cfg_reg_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] ext);
    logic [EXT_W-1:0] e;
    e = ext;
    if (ext == '0) begin
      e = EXT_W'(1);
    end else if (ext > EXT_MAX) begin
      e = EXT_MAX;
    end
    return e;
  endfunction

endpackage

FILE: hdl/swa_if.sv
interface swa_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface swa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [swa_pkg::OUT_ADDR_W-1:0]    strided_index;
  logic [swa_pkg::COUNT_W-1:0]       compact_index;
  logic                              last;

  modport source (output valid, output strided_index, output compact_index, output last,
                  input ready);
  modport sink   (input valid, input strided_index, input compact_index, input last,
                  output ready);
endinterface

interface swa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swa_pkg::CFG_IDX_W-1:0]  index;
  logic [swa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/strided_nd_address_walker_unit.sv
// Pipeline: the result of an accepted advance request passes through the issue stage, the
//   multiply stage and the sum into the output register before it reaches out_rsp.
// Throughput: one request per cycle; the three stages flow under out_rsp backpressure.
// A restart request, or an advance while no walk is armed, yields no result.
// Reset (rst_n low, synchronous): walk disarmed, pipeline emptied, registers to their
//   defaults (extents 1, inner stride 1, other strides 0, base 0).
module strided_nd_address_walker_unit #(
  parameter int MAX_DIMS  = swa_pkg::MAX_DIMS_DEF,
  parameter int ADDR_BITS = swa_pkg::ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swa_req_if.sink   in_req,
  swa_rsp_if.source out_rsp,
  swa_cfg_if.sink   cfg_wr
);

  // Only the innermost dimensions (at most three) map onto registers. Any extra
  // leading dimension has extent 1 and stride 0, so its position is always zero
  // and it adds nothing to the address: it needs no hardware.
  localparam int NACT    = (MAX_DIMS < swa_pkg::NUM_REG_DIMS) ? MAX_DIMS
                                                              : swa_pkg::NUM_REG_DIMS;
  localparam int REG_OFS = swa_pkg::NUM_REG_DIMS - NACT;
  localparam int SUM_W   = ADDR_BITS + swa_pkg::PROD_W;
  localparam int AEXT_W  = ADDR_BITS + swa_pkg::OUT_ADDR_W;

  // ---------------------------------------------------------------------------
  // Configuration registers (index 0 is outermost). Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [swa_pkg::EXT_W-1:0]    ext_r    [swa_pkg::NUM_REG_DIMS];
  logic [swa_pkg::STRIDE_W-1:0] stride_r [swa_pkg::NUM_REG_DIMS];
  logic [swa_pkg::BASE_W-1:0]   base_r;

  // Walk state
  logic [swa_pkg::POS_W-1:0]    pos_r   [NACT];
  logic [swa_pkg::POS_W-1:0]    pos_nxt [NACT];
  logic [swa_pkg::COUNT_W-1:0]  cnt_r;
  logic                         walking_r;

  // Issue stage: position snapshot of the element being emitted
  logic                         s1_v_r;
  logic [swa_pkg::POS_W-1:0]    s1_pos_r [NACT];
  logic [swa_pkg::COUNT_W-1:0]  s1_cnt_r;
  logic                         s1_last_r;

  // Multiply stage: stride times position per dimension
  logic                         s2_v_r;
  logic [swa_pkg::PROD_W-1:0]   s2_prod_r [NACT];
  logic [swa_pkg::COUNT_W-1:0]  s2_cnt_r;
  logic                         s2_last_r;

  // Output register
  logic                            out_v_r;
  logic [swa_pkg::OUT_ADDR_W-1:0]  out_addr_r;
  logic [swa_pkg::COUNT_W-1:0]     out_cnt_r;
  logic                            out_last_r;

  // Pipeline flow: each stage loads when its downstream neighbor frees up.
  logic out_free, s2_free, s1_free;
  logic req_acc, emit, at_end;
  logic [SUM_W-1:0]  addr_sum;
  logic [AEXT_W-1:0] addr_ext;

  assign out_free = !out_v_r || out_rsp.ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;

  assign in_req.ready = s1_free;
  assign cfg_wr.ready = 1'b1;

  assign req_acc = in_req.valid && in_req.ready;
  assign emit    = req_acc && !in_req.restart && walking_r;

  // Odometer: bump the innermost dimension not yet at its last position; every
  // dimension passed on the way wraps to zero. A carry out of the outermost
  // dimension marks the final element.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = NACT - 1; j >= 0; j--) begin
      pos_nxt[j] = pos_r[j];
      if (carry) begin
        if ((swa_pkg::EXT_W'(pos_r[j]) + swa_pkg::EXT_W'(1))
            < swa_pkg::eff_extent(ext_r[j + REG_OFS])) begin
          pos_nxt[j] = pos_r[j] + swa_pkg::POS_W'(1);
          carry      = 1'b0;
        end else begin
          pos_nxt[j] = '0;
        end
      end
    end
    at_end = carry;
  end

  // Base plus the registered products, kept modulo 2^ADDR_BITS and then fitted
  // to the 32-bit result field (zero filled when ADDR_BITS is narrower).
  always_comb begin
    addr_sum = SUM_W'(base_r);
    for (int j = 0; j < NACT; j++) begin
      addr_sum = addr_sum + SUM_W'(s2_prod_r[j]);
    end
    addr_ext = AEXT_W'(addr_sum[ADDR_BITS-1:0]);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < swa_pkg::NUM_REG_DIMS; r++) begin
        ext_r[r]    <= swa_pkg::EXT_RST;
        stride_r[r] <= swa_pkg::STRIDE_RST;
      end
      stride_r[swa_pkg::NUM_REG_DIMS-1] <= swa_pkg::STRIDE_INNER_RST;
      base_r    <= swa_pkg::BASE_RST;
      for (int j = 0; j < NACT; j++) begin
        pos_r[j] <= '0;
      end
      cnt_r     <= '0;
      walking_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (swa_pkg::cfg_reg_t'(cfg_wr.index))
          swa_pkg::CFG_EXT_OUTER:     ext_r[0]    <= cfg_wr.data[swa_pkg::EXT_W-1:0];
          swa_pkg::CFG_EXT_MIDDLE:    ext_r[1]    <= cfg_wr.data[swa_pkg::EXT_W-1:0];
          swa_pkg::CFG_EXT_INNER:     ext_r[2]    <= cfg_wr.data[swa_pkg::EXT_W-1:0];
          swa_pkg::CFG_STRIDE_OUTER:  stride_r[0] <= cfg_wr.data[swa_pkg::STRIDE_W-1:0];
          swa_pkg::CFG_STRIDE_MIDDLE: stride_r[1] <= cfg_wr.data[swa_pkg::STRIDE_W-1:0];
          swa_pkg::CFG_STRIDE_INNER:  stride_r[2] <= cfg_wr.data[swa_pkg::STRIDE_W-1:0];
          swa_pkg::CFG_BASE_OFFSET:   base_r      <= cfg_wr.data[swa_pkg::BASE_W-1:0];
          default: ;  // unmapped index: dropped
        endcase
      end

      if (req_acc && in_req.restart) begin
        for (int j = 0; j < NACT; j++) begin
          pos_r[j] <= '0;
        end
        cnt_r     <= '0;
        walking_r <= 1'b1;
      end else if (emit) begin
        pos_r     <= pos_nxt;
        cnt_r     <= cnt_r + swa_pkg::COUNT_W'(1);
        walking_r <= !at_end;
      end

      if (s1_free) begin
        s1_v_r <= emit;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload registers (no reset)
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_pos_r  <= pos_r;
      s1_cnt_r  <= cnt_r;
      s1_last_r <= at_end;
    end
    if (s2_free) begin
      for (int j = 0; j < NACT; j++) begin
        s2_prod_r[j] <= swa_pkg::PROD_W'(stride_r[j + REG_OFS])
                        * swa_pkg::PROD_W'(s1_pos_r[j]);
      end
      s2_cnt_r  <= s1_cnt_r;
      s2_last_r <= s1_last_r;
    end
    if (out_free) begin
      out_addr_r <= addr_ext[swa_pkg::OUT_ADDR_W-1:0];
      out_cnt_r  <= s2_cnt_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_rsp.valid         = out_v_r;
  assign out_rsp.strided_index = out_addr_r;
  assign out_rsp.compact_index = out_cnt_r;
  assign out_rsp.last          = out_last_r;

`ifndef SYNTHESIS
  // A restart never puts an element into the pipeline.
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc && in_req.restart |=> !s1_v_r)
    else $error("restart produced an element");

  // An advance during a walk always issues an element.
  a_advance_issues: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc && !in_req.restart && walking_r |=> s1_v_r)
    else $error("advance during walk issued nothing");

  // The walk ends only by issuing its final element.
  a_walk_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(walking_r) |-> s1_v_r && s1_last_r)
    else $error("walk ended without a final element");

  // While the final element sits in the issue stage no walk is armed.
  a_last_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> !walking_r)
    else $error("walk still armed behind its final element");
`endif

endmodule
